// ===== src/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table with binary search.
// ----------------------------------------------------------------------------
package skt_pkg;

    // field widths of the stream and configuration channels
    localparam int KEY_W      = 64;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int LEN_W      = 4;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    // item kinds carried in tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic CFG_ENTRY_COUNT    = 1'b0;
    localparam logic CFG_COMPARE_LENGTH = 1'b1;

    // reset values of the configuration registers
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET    = 9'd0;
    localparam logic [LEN_W-1:0]   COMPARE_LENGTH_RESET = 4'd8;

    // outcome of one key compare
    typedef struct packed {
        logic eq;   // keys equal within the compare length
        logic gt;   // search key greater than table key
    } t_cmp_res;

endpackage

// ===== src/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/skt_key_cmp.sv =====
// ----------------------------------------------------------------------------
// skt_key_cmp
// Byte-wise key compare, first character in the top byte, strncmp rules.
// ----------------------------------------------------------------------------
module skt_key_cmp import skt_pkg::*; #(
    parameter int KEY_BYTES = 8
) (
    input  logic [8*KEY_BYTES-1:0] i_a,
    input  logic [8*KEY_BYTES-1:0] i_b,
    input  logic [LEN_W-1:0]       i_len,
    output t_cmp_res               o_res
);

    localparam int KW = 8 * KEY_BYTES;

    // scan from the first character, stop at a difference or a shared nul
    always_comb begin
        logic [7:0] ba;
        logic [7:0] bb;
        logic       stop;
        stop     = 1'b0;
        o_res.eq = 1'b1;
        o_res.gt = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            ba = i_a[KW-1-8*i -: 8];
            bb = i_b[KW-1-8*i -: 8];
            if (!stop && (LEN_W'(i) < i_len)) begin
                if (ba != bb) begin
                    stop     = 1'b1;
                    o_res.eq = 1'b0;
                    o_res.gt = (ba > bb);
                end else if (ba == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/sorted_key_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search
// Sorted table of packed text keys in a RAM with a binary search over it.
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  load or search item
// m_axis    out  m_axis_tvalid / m_axis_tready  found flag and position
// cfg       in   i_cfg_valid / o_cfg_ready      register index and data
//
// A load item writes one RAM entry.
// A search item makes up to log2(depth)+1 probes, and one table RAM read
// per cycle sets the pace.
// An empty table decides its result in the accept cycle, without a probe.
// Reset is synchronous; the table RAM is not cleared.
// A result that is not taken waits in a holding register and stalls input.
// ----------------------------------------------------------------------------
module sorted_key_table_binary_search import skt_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // entry_index[7:0], key_bytes[71:8]
    input  logic                  s_axis_tuser,  // op[0]
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found[0], position[9:1], zero[15:10]
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [COUNT_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = 8 * KEY_BYTES;
    localparam logic [COUNT_W-1:0] DepthL    = COUNT_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]   KeyBytesL = LEN_W'(KEY_BYTES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_HOLD  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_entry_count;
    logic [LEN_W-1:0]   r_compare_length;
    logic [KW-1:0]      r_key, n_key;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [COUNT_W-1:0] r_low, n_low;
    logic [COUNT_W-1:0] r_high, n_high;
    logic [COUNT_W-1:0] r_mid, n_mid;
    logic               r_pend_found, n_pend_found;
    logic [COUNT_W-1:0] r_pend_pos, n_pend_pos;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [COUNT_W-1:0] r_out_pos, n_out_pos;

    logic               in_acc;
    logic               out_free;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [KW-1:0]      ram_rdata;
    logic [COUNT_W-1:0] count_sat;
    logic [LEN_W-1:0]   len_sat;
    logic [COUNT_W-1:0] lo_nx;
    logic [COUNT_W-1:0] hi_nx;
    logic               res_valid;
    logic               res_found;
    logic [COUNT_W-1:0] res_pos;
    t_cmp_res           cmp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // saturated count and compare length
    assign count_sat = (r_entry_count > DepthL) ? DepthL : r_entry_count;
    assign len_sat   = (r_compare_length > KeyBytesL) ? KeyBytesL : r_compare_length;

    // load items write the table, out-of-range slots are dropped
    assign ram_we = in_acc && (s_axis_tuser == OP_LOAD)
                    && ({1'b0, s_axis_tdata[INDEX_W-1:0]} < DepthL);

    skt_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[AW-1:0]),
        .i_wdata (s_axis_tdata[IN_DATA_W-1 -: KW]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    skt_key_cmp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_cmp (
        .i_a   (r_key),
        .i_b   (ram_rdata),
        .i_len (r_len),
        .o_res (cmp)
    );

    // bounds after the current probe
    assign lo_nx = cmp.gt ? (r_mid + COUNT_W'(1)) : r_low;
    assign hi_nx = cmp.gt ? r_high : r_mid;

    // search sequencer
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_len        = r_len;
        n_low        = r_low;
        n_high       = r_high;
        n_mid        = r_mid;
        n_pend_found = r_pend_found;
        n_pend_pos   = r_pend_pos;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        res_valid    = 1'b0;
        res_found    = 1'b0;
        res_pos      = '0;
        ram_raddr    = r_mid[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (s_axis_tuser == OP_SEARCH)) begin
                    n_key     = s_axis_tdata[IN_DATA_W-1 -: KW];
                    n_len     = len_sat;
                    n_low     = '0;
                    n_high    = count_sat;
                    n_mid     = count_sat >> 1;
                    ram_raddr = n_mid[AW-1:0];
                    if (count_sat != '0) begin
                        n_state = ST_PROBE;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (cmp.eq) begin
                    res_valid = 1'b1;
                    res_found = 1'b1;
                    res_pos   = r_mid;
                end else if (lo_nx < hi_nx) begin
                    n_low     = lo_nx;
                    n_high    = hi_nx;
                    n_mid     = lo_nx + ((hi_nx - lo_nx) >> 1);
                    ram_raddr = n_mid[AW-1:0];
                end else begin
                    res_valid = 1'b1;
                    res_pos   = lo_nx;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_pend_found;
                    n_out_pos   = r_pend_pos;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // deliver the result now, or park it until the output frees up
        if (res_valid) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_found = res_found;
                n_out_pos   = res_pos;
                n_state     = ST_IDLE;
            end else begin
                n_pend_found = res_found;
                n_pend_pos   = res_pos;
                n_state      = ST_HOLD;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // search payload registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_len        <= n_len;
        r_low        <= n_low;
        r_high       <= n_high;
        r_mid        <= n_mid;
        r_pend_found <= n_pend_found;
        r_pend_pos   <= n_pend_pos;
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= ENTRY_COUNT_RESET;
            r_compare_length <= COMPARE_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENTRY_COUNT:    r_entry_count    <= i_cfg_data;
                CFG_COMPARE_LENGTH: r_compare_length <= i_cfg_data[LEN_W-1:0];
                default:            r_entry_count    <= r_entry_count;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-COUNT_W-1){1'b0}}, r_out_pos, r_out_found};

`ifndef SYNTHESIS
    // probe index always lies inside the live search window
    a_mid_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_low <= r_mid && r_mid < r_high))
        else $error("probe index outside search window");

    // a found index names a real table slot
    a_found_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_pos < DepthL))
        else $error("found position beyond table depth");

    // the table is written only between searches
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("table written during a search");

    // a parked result reaches the output once it frees up
    a_hold_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("parked result not delivered");
`endif

endmodule
